// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Clocked assertion wrappers shared by the RTL, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: rtl/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Types and constants for the 3x3 stride-1 window convolution.
// ----------------------------------------------------------------------------
package cnv_pkg;

   localparam int PIXEL_BITS     = 16;
   localparam int WEIGHT_BITS    = 16;
   localparam int ACC_BITS       = 48;
   localparam int ROW_BITS       = 48;
   localparam int KERNEL_SIZE    = 3;
   localparam int WINDOW_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CSR_IDX_BITS   = 4;
   localparam int WIDTH_CFG_BITS = 11;
   localparam int MIN_WIDTH      = 3;

   localparam int PROD_BITS   = PIXEL_BITS + WEIGHT_BITS;
   localparam int ROWSUM_BITS = PROD_BITS + 2;
   localparam int TOTAL_BITS  = PROD_BITS + 4;
   localparam int SUM_BITS    = ACC_BITS + 1;

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KERNEL_TOP    = 4'd0,
      CSR_KERNEL_MID    = 4'd1,
      CSR_KERNEL_BOTTOM = 4'd2,
      CSR_PLANE_WIDTH   = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel;
      logic signed [ACC_BITS-1:0]   partial_sum;
      logic                         end_of_plane;
   } req_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] conv_sum;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] partial_sum;
      logic                       last;
   } tag_type;

   typedef logic [WINDOW_TAPS-1:0][PIXEL_BITS-1:0]  window_type;
   typedef logic [WINDOW_TAPS-1:0][WEIGHT_BITS-1:0] weights_type;

endpackage

// File: rtl/conv3x3_stride1_window.sv
// ----------------------------------------------------------------------------
// conv3x3_stride1_window
// Streaming 3x3 stride-1 convolution of one padded plane with line stores.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order and, once a full 3x3 window is
// present, returns the partial sum plus the window dot product with the nine
// weights, saturated to 48 bits. The two previous rows live in one line
// memory read on acceptance and written back from the read stage, with
// same-entry forwarding, so a new pixel enters every cycle as long as the
// result side keeps up. After reset the memory reads as zero through a fill
// count; there is no clearing pass. Write weights and plane width through
// the csr port only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module conv3x3_stride1_window import cnv_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ROW_BITS-1:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int FW = $clog2(MAX_WIDTH + 1);
   localparam int WW = (FW > WIDTH_CFG_BITS) ? FW : WIDTH_CFG_BITS;
   localparam logic [1:0] ROW_FULL = 2'(KERNEL_SIZE - 1);

   logic [ROW_BITS-1:0]   krow_ff [KERNEL_SIZE];
   logic [WW-1:0]         width_ff;
   logic [WW-1:0]         width_in;
   logic [CW-1:0]         col_ff, col_in, col_use;
   logic [1:0]            row_ff, row_in;
   logic [WW-1:0]         col_step;
   logic                  col_wrap;
   logic                  req_accept;
   logic                  produce;

   logic                  s1_v_ff;
   logic                  s1_prod_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [PIXEL_BITS-1:0] s1_px_ff;
   tag_type               s1_tag_ff;
   logic                  s1_go, s1_rdy;

   logic [PIXEL_BITS-1:0]   win_ff [KERNEL_SIZE][2];
   logic [PIXEL_BITS-1:0]   newcol [KERNEL_SIZE];
   logic [2*PIXEL_BITS-1:0] rd_word;
   logic [2*PIXEL_BITS-1:0] wr_word;
   window_type              window;
   weights_type             weights;
   logic                    mac_ready;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      width_in = WW'(csr_wdata[WIDTH_CFG_BITS-1:0]);
      if (width_in < WW'(MIN_WIDTH)) begin
         width_in = WW'(MIN_WIDTH);
      end else if (width_in > WW'(MAX_WIDTH)) begin
         width_in = WW'(MAX_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            krow_ff[i] <= '0;
         end
         width_ff <= WW'(MIN_WIDTH);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_TOP:    krow_ff[0] <= csr_wdata;
            CSR_KERNEL_MID:    krow_ff[1] <= csr_wdata;
            CSR_KERNEL_BOTTOM: krow_ff[2] <= csr_wdata;
            CSR_PLANE_WIDTH:   width_ff   <= width_in;
            default: ;
         endcase
      end
   end

   // column and row counters
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      col_use = col_ff;
      if (WW'(col_ff) >= width_ff) begin
         col_use = CW'(width_ff - 1'b1);
      end
      col_step = WW'(col_use) + 1'b1;
      col_wrap = col_step >= width_ff;
      produce  = (row_ff == ROW_FULL) && (col_use >= CW'(KERNEL_SIZE - 1));

      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (req_data.end_of_plane) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            if (row_ff != ROW_FULL) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = CW'(col_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // read stage and write-back
   assign s1_go     = s1_v_ff && (!s1_prod_ff || mac_ready);
   assign s1_rdy    = !s1_v_ff || s1_go;
   assign req_stall = !s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_prod_ff            <= produce;
         s1_col_ff             <= col_use;
         s1_px_ff              <= req_data.pixel;
         s1_tag_ff.partial_sum <= req_data.partial_sum;
         s1_tag_ff.last        <= req_data.end_of_plane;
      end
   end

   // word layout: upper line in low half, lower line in high half
   assign newcol[0] = rd_word[PIXEL_BITS-1:0];
   assign newcol[1] = rd_word[2*PIXEL_BITS-1:PIXEL_BITS];
   assign newcol[2] = s1_px_ff;
   assign wr_word   = {s1_px_ff, rd_word[2*PIXEL_BITS-1:PIXEL_BITS]};

   cnv_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .WORD_BITS (2 * PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (col_use),
      .rd_word (rd_word),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            win_ff[i][0] <= '0;
            win_ff[i][1] <= '0;
         end
      end else if (s1_go) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= newcol[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         window[i*KERNEL_SIZE]     = win_ff[i][0];
         window[i*KERNEL_SIZE + 1] = win_ff[i][1];
         window[i*KERNEL_SIZE + 2] = newcol[i];
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            weights[i*KERNEL_SIZE + j] = krow_ff[i][j*WEIGHT_BITS +: WEIGHT_BITS];
         end
      end
   end

   cnv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_go && s1_prod_ff),
      .in_ready  (mac_ready),
      .window    (window),
      .weights   (weights),
      .tag       (s1_tag_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEVER(a_row_sat, clock, reset, row_ff > ROW_FULL)
   `ASSERT_CLK(a_eop_restart, clock, reset, req_accept && req_data.end_of_plane |=> col_ff == '0 && row_ff == '0)
   `ASSERT_CLK(a_col_step, clock, reset, req_accept && !req_data.end_of_plane && !col_wrap |=> WW'(col_ff) == $past(col_step))

endmodule

// File: rtl/cnv_line_mem.sv
// ----------------------------------------------------------------------------
// cnv_line_mem
// Line store memory, one read and one write port, with a fill count for
// never-written entries and forwarding of a same-address write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnv_line_mem import cnv_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [WORD_BITS-1:0]         rd_word,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [WORD_BITS-1:0]         wr_data
);

   localparam int FW = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;
   logic                 rd_ok_ff;
   logic                 fwd_hit_ff;
   logic [FW-1:0]        fill_ff;
   logic [FW-1:0]        fill_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (wr_en && FW'(wr_addr) == fill_ff) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_ok_ff   <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            rd_ok_ff   <= FW'(rd_addr) < fill_ff;
            fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   // unwritten entries read as zero
   assign rd_word = fwd_hit_ff ? fwd_data_ff : (rd_ok_ff ? rd_data_ff : '0);

   `ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > FW'(DEPTH))
   `ASSERT_CLK(a_write_prefix, clock, reset, wr_en |-> FW'(wr_addr) <= fill_ff)
   `ASSERT_CLK(a_fill_by_write, clock, reset, fill_ff != $past(fill_ff) |-> $past(wr_en))

endmodule

// File: rtl/cnv_mac.sv
// ----------------------------------------------------------------------------
// cnv_mac
// Nine-tap multiply and add tree with saturating partial-sum accumulate.
// ----------------------------------------------------------------------------
module cnv_mac import cnv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  window_type  window,
   input  weights_type weights,
   input  tag_type     tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic signed [PROD_BITS-1:0]   prod_ff [WINDOW_TAPS];
   logic signed [ROWSUM_BITS-1:0] rowsum_ff [KERNEL_SIZE];
   logic signed [TOTAL_BITS-1:0]  total_ff;
   logic signed [SUM_BITS-1:0]    sum_in;
   tag_type                       tag2_ff, tag3_ff, tag4_ff;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;
   logic                          v2_ff, v3_ff, v4_ff, vo_ff;
   logic                          rdy2, rdy3, rdy4, rdyo;

   assign rdyo     = !vo_ff || !rsp_stall;
   assign rdy4     = !v4_ff || rdyo;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   always_comb begin
      sum_in = SUM_BITS'($signed(tag4_ff.partial_sum)) + SUM_BITS'(total_ff);
      rsp_in.last = tag4_ff.last;
      if (sum_in[SUM_BITS-1] != sum_in[SUM_BITS-2]) begin
         rsp_in.conv_sum = sum_in[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
      end else begin
         rsp_in.conv_sum = sum_in[ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         for (int k = 0; k < WINDOW_TAPS; k++) begin
            prod_ff[k] <= PROD_BITS'($signed(window[k]) * $signed(weights[k]));
         end
         tag2_ff <= tag;
      end
      if (rdy3) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            rowsum_ff[i] <= ROWSUM_BITS'(prod_ff[i*KERNEL_SIZE])
                          + ROWSUM_BITS'(prod_ff[i*KERNEL_SIZE+1])
                          + ROWSUM_BITS'(prod_ff[i*KERNEL_SIZE+2]);
         end
         tag3_ff <= tag2_ff;
      end
      if (rdy4) begin
         total_ff <= TOTAL_BITS'(rowsum_ff[0]) + TOTAL_BITS'(rowsum_ff[1])
                   + TOTAL_BITS'(rowsum_ff[2]);
         tag4_ff  <= tag3_ff;
      end
      if (rdyo && v4_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy2) v2_ff <= in_valid;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdyo) vo_ff <= v4_ff;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

endmodule
